FILE: hdl/tga_rle_pkg.sv
// ----------------------------------------------------------------------------
// tga_rle_pkg
// Types, codes and constants shared by the TGA run-length decoder modules.
// ----------------------------------------------------------------------------
package tga_rle_pkg;

	localparam int unsigned HDR_LAST_INDEX = 17;
	localparam int unsigned SIG_LEN        = 12;
	localparam logic [7:0]  SIG_IMAGE_TYPE = 8'h0A;
	localparam logic [4:0]  SIG_TYPE_INDEX = 5'd2;
	localparam logic [7:0]  DEPTH_24       = 8'd24;
	localparam logic [7:0]  DEPTH_32       = 8'd32;

	localparam logic [1:0] KIND_PIXEL   = 2'd0;
	localparam logic [1:0] KIND_HDR_OK  = 2'd1;
	localparam logic [1:0] KIND_HDR_BAD = 2'd2;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SIGNATURE = 2'd1;
	localparam logic [1:0] ERR_ZERO_SIZE = 2'd2;
	localparam logic [1:0] ERR_DEPTH     = 2'd3;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PACKET,
		PH_PIXEL,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic [7:0]  repeat_res;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic        alpha_present;
		logic [1:0]  error_code;
		logic        final_pixels;
		logic        clipped;
	} out_word_t;

	// Expected value of a signature byte of the header.
	function automatic logic [7:0] sig_byte(input logic [4:0] idx);
		sig_byte = (idx == SIG_TYPE_INDEX) ? SIG_IMAGE_TYPE : 8'h00;
	endfunction

endpackage

FILE: hdl/tga_rle_core.sv
// ----------------------------------------------------------------------------
// tga_rle_core
// Header checker and packet parser. Consumes one file byte per accepted word
// and produces at most one result word in the same cycle.
// ----------------------------------------------------------------------------
module tga_rle_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  tga_rle_pkg::in_word_t  word,
	output logic                   res_push,
	output tga_rle_pkg::out_word_t res_word
);

	tga_rle_pkg::phase_t phase_q, phase_d, eff_phase;

	logic [4:0]  idx_q, idx_d, eff_idx;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic        alpha_q, alpha_d;
	logic [31:0] pixels_q, pixels_d;
	logic        is_run_q, is_run_d;
	logic [7:0]  packet_q, packet_d;
	logic [1:0]  bip_q, bip_d;
	logic        sigbad_q, sigbad_d, eff_sigbad;
	logic [7:0]  depth_q, depth_d;
	logic [7:0]  pix_q [3];
	logic        pix_we;

	logic [7:0]  b;
	logic        hdr_last;
	logic [1:0]  hdr_err;
	logic        pix_last;
	logic        run_clip;
	logic [7:0]  run_rep;
	logic [31:0] pixels_next;
	logic [7:0]  packet_next;
	logic [7:0]  packet_raw;
	logic        fin;
	logic        clip;

	assign b          = word.data_byte;
	assign eff_phase  = word.start_of_file ? tga_rle_pkg::PH_HEADER : phase_q;
	assign eff_idx    = word.start_of_file ? 5'd0 : idx_q;
	assign eff_sigbad = word.start_of_file ? 1'b0 : sigbad_q;

	assign hdr_last = (eff_idx >= 5'(tga_rle_pkg::HDR_LAST_INDEX));

	always_comb begin
		if (eff_sigbad) begin
			hdr_err = tga_rle_pkg::ERR_SIGNATURE;
		end else if (width_q == 16'd0 || height_q == 16'd0) begin
			hdr_err = tga_rle_pkg::ERR_ZERO_SIZE;
		end else if (depth_q != tga_rle_pkg::DEPTH_24 && depth_q != tga_rle_pkg::DEPTH_32) begin
			hdr_err = tga_rle_pkg::ERR_DEPTH;
		end else begin
			hdr_err = tga_rle_pkg::ERR_NONE;
		end
	end

	// The last byte of a pixel is red for 24-bit data and alpha for 32-bit data.
	assign pix_last = (bip_q == (alpha_q ? 2'd3 : 2'd2));

	// A run never goes past the pixels left in the image.
	assign run_clip = ({24'd0, packet_q} > pixels_q);
	assign run_rep  = run_clip ? pixels_q[7:0] : packet_q;

	assign packet_raw  = (packet_q != 8'd0) ? packet_q - 8'd1 : 8'd0;
	assign pixels_next = is_run_q ? pixels_q - {24'd0, run_rep}
	                              : ((pixels_q != 32'd0) ? pixels_q - 32'd1 : 32'd0);
	assign packet_next = is_run_q ? 8'd0 : packet_raw;
	assign fin         = (pixels_next == 32'd0);
	assign clip        = is_run_q ? run_clip : (fin && packet_raw != 8'd0);

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (take) begin
			unique case (eff_phase)
				tga_rle_pkg::PH_HEADER: begin
					if (hdr_last) begin
						phase_d = (hdr_err != tga_rle_pkg::ERR_NONE) ? tga_rle_pkg::PH_DONE
						                                             : tga_rle_pkg::PH_PACKET;
					end else begin
						phase_d = tga_rle_pkg::PH_HEADER;
					end
				end
				tga_rle_pkg::PH_PACKET: begin
					phase_d = tga_rle_pkg::PH_PIXEL;
				end
				tga_rle_pkg::PH_PIXEL: begin
					if (pix_last) begin
						if (fin) begin
							phase_d = tga_rle_pkg::PH_DONE;
						end else if (packet_next == 8'd0) begin
							phase_d = tga_rle_pkg::PH_PACKET;
						end else begin
							phase_d = tga_rle_pkg::PH_PIXEL;
						end
					end else begin
						phase_d = tga_rle_pkg::PH_PIXEL;
					end
				end
				tga_rle_pkg::PH_DONE: begin
					phase_d = tga_rle_pkg::PH_DONE;
				end
				default: begin
					phase_d = tga_rle_pkg::PH_DONE;
				end
			endcase
		end
	end

	// Datapath and result word.
	always_comb begin
		idx_d    = idx_q;
		width_d  = width_q;
		height_d = height_q;
		alpha_d  = alpha_q;
		pixels_d = pixels_q;
		is_run_d = is_run_q;
		packet_d = packet_q;
		bip_d    = bip_q;
		sigbad_d = sigbad_q;
		depth_d  = depth_q;
		pix_we   = 1'b0;
		res_push = 1'b0;
		res_word = '0;
		res_word.image_width   = width_q;
		res_word.image_height  = height_q;
		res_word.alpha_present = alpha_q;
		if (take) begin
			idx_d    = eff_idx;
			sigbad_d = eff_sigbad;
			unique case (eff_phase)
				tga_rle_pkg::PH_HEADER: begin
					if (hdr_last) begin
						res_push            = 1'b1;
						res_word.kind       = (hdr_err != tga_rle_pkg::ERR_NONE)
						                      ? tga_rle_pkg::KIND_HDR_BAD
						                      : tga_rle_pkg::KIND_HDR_OK;
						res_word.error_code = hdr_err;
						pixels_d            = 32'(width_q) * 32'(height_q);
					end else begin
						idx_d = eff_idx + 5'd1;
						if (eff_idx < 5'(tga_rle_pkg::SIG_LEN)) begin
							if (b != tga_rle_pkg::sig_byte(eff_idx)) begin
								sigbad_d = 1'b1;
							end
						end else begin
							case (eff_idx)
								5'd12: width_d  = {width_q[15:8], b};
								5'd13: width_d  = {b, width_q[7:0]};
								5'd14: height_d = {height_q[15:8], b};
								5'd15: height_d = {b, height_q[7:0]};
								default: begin
									depth_d = b;
									alpha_d = (b == tga_rle_pkg::DEPTH_32);
								end
							endcase
						end
					end
				end
				tga_rle_pkg::PH_PACKET: begin
					is_run_d = b[7];
					packet_d = {1'b0, b[6:0]} + 8'd1;
					bip_d    = 2'd0;
				end
				tga_rle_pkg::PH_PIXEL: begin
					if (pix_last) begin
						res_push              = 1'b1;
						res_word.kind         = tga_rle_pkg::KIND_PIXEL;
						res_word.red          = alpha_q ? pix_q[2] : b;
						res_word.green        = pix_q[1];
						res_word.blue         = pix_q[0];
						res_word.alpha        = alpha_q ? b : 8'd0;
						res_word.repeat_res   = is_run_q ? run_rep : 8'd1;
						res_word.error_code   = tga_rle_pkg::ERR_NONE;
						res_word.final_pixels = fin;
						res_word.clipped      = clip;
						pixels_d              = pixels_next;
						packet_d              = packet_next;
						bip_d                 = 2'd0;
					end else begin
						pix_we = 1'b1;
						bip_d  = bip_q + 2'd1;
					end
				end
				tga_rle_pkg::PH_DONE: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tga_rle_pkg::PH_HEADER;
			idx_q    <= 5'd0;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			alpha_q  <= 1'b0;
			pixels_q <= 32'd0;
			is_run_q <= 1'b0;
			packet_q <= 8'd0;
			bip_q    <= 2'd0;
			sigbad_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			idx_q    <= idx_d;
			width_q  <= width_d;
			height_q <= height_d;
			alpha_q  <= alpha_d;
			pixels_q <= pixels_d;
			is_run_q <= is_run_d;
			packet_q <= packet_d;
			bip_q    <= bip_d;
			sigbad_q <= sigbad_d;
		end
	end

	// Pixel bytes and depth are payload; every read follows a write.
	always_ff @(posedge clk) begin
		depth_q <= depth_d;
		if (pix_we && bip_q != 2'd3) begin
			pix_q[bip_q] <= b;
		end
	end

endmodule

FILE: hdl/tga_rle_outq.sv
// ----------------------------------------------------------------------------
// tga_rle_outq
// Two-word result queue that decouples the parser from the result stall.
// ----------------------------------------------------------------------------
module tga_rle_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tga_rle_pkg::out_word_t push_word,
	output logic                   ready,
	output logic                   res_valid,
	input  logic                   res_stall,
	output tga_rle_pkg::out_word_t res_word
);

	logic [1:0]             count_q;
	tga_rle_pkg::out_word_t head_q;
	tga_rle_pkg::out_word_t tail_q;
	logic                   pop;

	assign ready     = (count_q != 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign res_word  = head_q;
	assign pop       = res_valid && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					head_q <= push_word;
				end else begin
					tail_q <= push_word;
				end
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				// Only reachable with one word held: the new word becomes the head.
				head_q <= push_word;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hdl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// Decoder for run-length compressed TGA files, type 10, 24 or 32 bits per pixel.
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle and gives at most one result word per
// byte: a header word after the eighteenth header byte, and a pixel word for
// each run packet or raw pixel, with colors in RGBA order. Each byte is handled
// in the cycle it is accepted by the parser state registers, and its result
// lands in a two-word output queue, so bytes keep flowing while a result waits.
// The byte side stalls only when both queue entries are full.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   src_valid,
	output logic                   src_stall,
	input  tga_rle_pkg::in_word_t  src_word,
	output logic                   res_valid,
	input  logic                   res_stall,
	output tga_rle_pkg::out_word_t res_word
);

	logic                   take;
	logic                   q_ready;
	logic                   push;
	tga_rle_pkg::out_word_t push_word;

	assign src_stall = !q_ready;
	assign take      = src_valid && q_ready;

	tga_rle_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.word     (src_word),
		.res_push (push),
		.res_word (push_word)
	);

	tga_rle_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.ready     (q_ready),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule
